### rtl/pip_pkg.sv
`timescale 1ns / 1ps
// shared codes for the point in polygon test core
// no dependencies
package pip_pkg;

	// transaction kinds carried on the action port
	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage

### rtl/point_in_polygon_test_core.sv
`timescale 1ns / 1ps
// point in polygon test by ray casting over one stored polygon
// depends on pip_pkg
//
// A transaction is taken when start is high and busy is low. Every transaction gives exactly one
// result: done is high for one cycle, the cycle after the transaction ends, with inside_res and
// status valid; the receiver cannot stall it. Start, append, unused actions, queries on an empty
// polygon and queries that fall outside the bounding box finish without raising busy, and the
// block can take the next transaction in the very cycle that its result is shown. A query inside
// the box walks the stored edges with one shared multiplier: busy stays high while it fetches
// the first vertex pair, takes each edge through a difference step and the two products that
// each edge needs from that multiplier, and resolves the last crossing. Vertices sit in a
// register file of MAX_VERTICES entries with one write port and a registered read port; appends
// to a full store are dropped with status full. Points on the box edge count as within the box;
// horizontal edges never count as crossings.
module point_in_polygon_test_core
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          done,
	output logic                          inside_res,
	output logic [1:0]                    status
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;  // vertex address
	localparam int CW = $clog2(MAX_VERTICES + 1);                       // vertex count
	localparam int DW = COORD_WIDTH + 1;                                // coordinate difference
	localparam int PW = 2 * DW;                                         // cross product term

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH_J,
		ST_FETCH_I,
		ST_DIFF,
		ST_MUL_A,
		ST_MUL_B,
		ST_FINISH
	} state_t;

	state_t state_q;

	// vertex store, no reset: only entries below the count feed a result
	logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
	logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
	logic signed [COORD_WIDTH-1:0] rd_x_q, rd_y_q;

	// polygon state
	logic [CW-1:0]                 count_q;
	logic signed [COORD_WIDTH-1:0] min_x_q, max_x_q, min_y_q, max_y_q;

	// walk control
	logic [AW-1:0] addr_q;
	logic [AW-1:0] idx_q;
	logic          pend_q;   // a finished edge waits for its compare
	logic          acc_q;    // running inside flag

	// edge datapath
	logic signed [COORD_WIDTH-1:0] px_q, py_q;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
	logic signed [DW-1:0]          dxp_q, dy_q, dxe_q, dyp_q;
	logic                          cond_q, dypos_q;
	logic signed [PW-1:0]          prod_a_q, prod_b_q;

	logic                 accept;
	logic                 full;
	logic                 in_box;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        last_idx;
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] product;
	logic                 crossing;
	logic                 toggle;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q >= CW'(MAX_VERTICES));

	// boundary points count as within the box
	assign in_box = (coord_x >= min_x_q) && (coord_x <= max_x_q) &&
	                (coord_y >= min_y_q) && (coord_y <= max_y_q);

	assign wr_en   = accept && ((action == ACT_START) || ((action == ACT_APPEND) && !full));
	assign wr_addr = (action == ACT_START) ? '0 : count_q[AW-1:0];
	assign last_idx = AW'(count_q - CW'(1));

	// the shared multiplier: (px - xi) * dy first, then (xj - xi) * (py - yi)
	assign mul_a   = (state_q == ST_MUL_A) ? dxp_q : dxe_q;
	assign mul_b   = (state_q == ST_MUL_A) ? dy_q  : dyp_q;
	assign product = PW'(mul_a) * PW'(mul_b);

	// exact crossing test, the inequality flips when dy is negative
	assign crossing = dypos_q ? (prod_a_q < prod_b_q) : (prod_b_q < prod_a_q);
	assign toggle   = pend_q && cond_q && crossing;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= coord_x;
			mem_y[wr_addr] <= coord_y;
		end
		rd_x_q <= mem_x[addr_q];
		rd_y_q <= mem_y[addr_q];
	end

	// edge datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		case (state_q)
			ST_FETCH_I: begin
				prev_x_q <= rd_x_q;
				prev_y_q <= rd_y_q;
			end
			ST_DIFF: begin
				dxp_q    <= DW'(px_q) - DW'(rd_x_q);
				dy_q     <= DW'(prev_y_q) - DW'(rd_y_q);
				dxe_q    <= DW'(prev_x_q) - DW'(rd_x_q);
				dyp_q    <= DW'(py_q) - DW'(rd_y_q);
				cond_q   <= (rd_y_q > py_q) != (prev_y_q > py_q);
				dypos_q  <= (prev_y_q > rd_y_q);
				prev_x_q <= rd_x_q;
				prev_y_q <= rd_y_q;
			end
			ST_MUL_A: prod_a_q <= product;
			ST_MUL_B: prod_b_q <= product;
			default: ;
		endcase
	end

	// sequencer, polygon state and result outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			min_x_q    <= '0;
			max_x_q    <= '0;
			min_y_q    <= '0;
			max_y_q    <= '0;
			addr_q     <= '0;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			acc_q      <= 1'b0;
			done       <= 1'b0;
			inside_res <= 1'b0;
			status     <= STAT_OK;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						inside_res <= 1'b0;
						status     <= STAT_OK;
						case (action)
							ACT_START: begin
								count_q <= CW'(1);
								min_x_q <= coord_x;
								max_x_q <= coord_x;
								min_y_q <= coord_y;
								max_y_q <= coord_y;
								done    <= 1'b1;
							end
							ACT_APPEND: begin
								done <= 1'b1;
								if (full) begin
									status <= STAT_FULL;
								end else begin
									count_q <= count_q + CW'(1);
									if (count_q == '0) begin
										min_x_q <= coord_x;
										max_x_q <= coord_x;
										min_y_q <= coord_y;
										max_y_q <= coord_y;
									end else begin
										if (coord_x < min_x_q) min_x_q <= coord_x;
										if (coord_x > max_x_q) max_x_q <= coord_x;
										if (coord_y < min_y_q) min_y_q <= coord_y;
										if (coord_y > max_y_q) max_y_q <= coord_y;
									end
								end
							end
							ACT_QUERY: begin
								if (count_q == '0) begin
									status <= STAT_EMPTY;
									done   <= 1'b1;
								end else if (!in_box) begin
									done <= 1'b1;
								end else begin
									// first edge starts at the last vertex
									addr_q  <= last_idx;
									idx_q   <= '0;
									pend_q  <= 1'b0;
									acc_q   <= 1'b0;
									state_q <= ST_FETCH_J;
								end
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				ST_FETCH_J: begin
					addr_q  <= '0;
					state_q <= ST_FETCH_I;
				end
				ST_FETCH_I: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					// resolve the previous edge while this one is taken apart
					if (toggle) acc_q <= ~acc_q;
					addr_q  <= AW'(idx_q + AW'(1));
					state_q <= ST_MUL_A;
				end
				ST_MUL_A: begin
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					pend_q <= 1'b1;
					if (idx_q == last_idx) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_DIFF;
					end
				end
				ST_FINISH: begin
					inside_res <= acc_q ^ toggle;
					status     <= STAT_OK;
					done       <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/pip_checker.sv
`timescale 1ns / 1ps
// port level checks for the point in polygon test core, bound to the top level
// depends on pip_pkg and point_in_polygon_test_core
module pip_checker
	import pip_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       inside_res,
	input logic [1:0] status
);

	// an accepted transaction either answers at once or keeps the core busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("transaction neither answered nor in progress");

	// a finished walk always presents its result
	a_walk_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk ended without a result");

	// no result while a walk is still running
	a_no_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result shown during a walk");

	// error results never claim inside
	a_error_outside: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |-> !inside_res)
		else $error("inside flagged on an error result");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.inside_res (inside_res),
	.status     (status)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for point_in_polygon_test_core: polygon loads and point queries
// depends on pip_pkg and point_in_polygon_test_core
module tb_top;
	import pip_pkg::*;

	localparam int COORD_W    = 24;
	localparam int MAX_VERT   = 64;
	localparam int N_ITEMS    = 650;
	localparam int QUIET_MAX  = 4000;  // covers the longest query walk plus sender gaps
	localparam int DRAIN_WAIT = 20;

	// action 3 is not decoded by the block
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

	// one transaction toward the block, with the idle rate of its phase
	typedef struct {
		logic [1:0] act;
		coord_t     x;
		coord_t     y;
		int         idle_pct;
	} poly_cmd_t;

	// one result from the block
	typedef struct {
		logic       in_poly;
		logic [1:0] status;
	} poly_answer_t;

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       start    = 1'b0;
	logic [1:0] action   = ACT_START;
	coord_t     coord_x  = '0;
	coord_t     coord_y  = '0;
	logic       busy;
	logic       done;
	logic       inside_res;
	logic [1:0] status;

	poly_cmd_t    command_queue[$];    // transactions not yet put on the bus
	poly_answer_t pending_answers[$];  // predicted results not yet seen
	poly_cmd_t    cmd_on_bus;
	int           gen_count;
	int           mismatch_count;
	int           quiet_cycles;

	// predictor copy of the polygon store and its bounding box
	coord_t      poly_vx[MAX_VERT];
	coord_t      poly_vy[MAX_VERT];
	int unsigned poly_count;
	coord_t      box_lo_x, box_hi_x, box_lo_y, box_hi_y;

	point_in_polygon_test_core #(
		.MAX_VERTICES(MAX_VERT),
		.COORD_WIDTH (COORD_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.done      (done),
		.inside_res(inside_res),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// add a vertex and grow the box; the first vertex sets the box outright
	function automatic void store_poly_vertex(coord_t x, coord_t y);
		poly_vx[poly_count] = x;
		poly_vy[poly_count] = y;
		if (poly_count == 0) begin
			box_lo_x = x;
			box_hi_x = x;
			box_lo_y = y;
			box_hi_y = y;
		end else begin
			if (x < box_lo_x) box_lo_x = x;
			if (x > box_hi_x) box_hi_x = x;
			if (y < box_lo_y) box_lo_y = y;
			if (y > box_hi_y) box_hi_y = y;
		end
		poly_count++;
	endfunction

	// ray cast toward +x; crossings found by comparing cross products exactly
	function automatic logic point_in_poly(coord_t qx, coord_t qy);
		longint px, py, xi, yi, xj, yj, dy, lhs, rhs;
		int unsigned j;
		logic odd;
		logic hit;
		odd = 1'b0;
		px  = qx;
		py  = qy;
		// points beyond the box are outside; box edges count as within
		if (qx < box_lo_x || qx > box_hi_x || qy < box_lo_y || qy > box_hi_y)
			return 1'b0;
		j = poly_count - 1;
		for (int unsigned i = 0; i < poly_count; i++) begin
			xi = poly_vx[i];
			yi = poly_vy[i];
			xj = poly_vx[j];
			yj = poly_vy[j];
			// horizontal edges never straddle the ray, so never count
			if ((yi > py) != (yj > py)) begin
				dy  = yj - yi;
				lhs = (px - xi) * dy;
				rhs = (xj - xi) * (py - yi);
				hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
				if (hit)
					odd = ~odd;
			end
			j = i;
		end
		return odd;
	endfunction

	// apply one accepted transaction to the predictor and give its result
	function automatic poly_answer_t apply_poly_cmd(poly_cmd_t c);
		poly_answer_t a;
		a.in_poly = 1'b0;
		a.status  = STAT_OK;
		case (c.act)
			ACT_START: begin
				poly_count = 0;
				store_poly_vertex(c.x, c.y);
			end
			ACT_APPEND: begin
				// a full store drops the vertex
				if (poly_count >= MAX_VERT)
					a.status = STAT_FULL;
				else
					store_poly_vertex(c.x, c.y);
			end
			ACT_QUERY: begin
				if (poly_count == 0)
					a.status = STAT_EMPTY;
				else
					a.in_poly = point_in_poly(c.x, c.y);
			end
			default: ;  // unused action leaves everything as is
		endcase
		return a;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// sender idle rate by phase: none, heavy, none, moderate
	function automatic int idle_for(int n);
		case ((n / 165) % 4)
			1:       return 61;
			3:       return 31;
			default: return 0;
		endcase
	endfunction

	function automatic void queue_cmd(logic [1:0] act, int x, int y);
		poly_cmd_t c;
		c.act      = act;
		c.x        = coord_t'(x);
		c.y        = coord_t'(y);
		c.idle_pct = idle_for(gen_count);
		command_queue.insert(command_queue.size(), c);
		gen_count++;
	endfunction

	// span 0 means the full signed coordinate range
	function automatic int rand_coord(int span);
		coord_t v;
		if (span == 0)
			v = coord_t'($urandom());
		else
			v = coord_t'(int'($urandom_range(0, 2 * span)) - span);
		return int'(v);
	endfunction

	function automatic int pick_span();
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 16;
			2:       return 1000;
			3:       return 100000;
			default: return 50;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// driver: takes transactions from command_queue, predicts on acceptance
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				pending_answers.insert(pending_answers.size(), apply_poly_cmd(cmd_on_bus));
			// a new transaction may go out once the current one is taken or none is up
			if (!start || !busy) begin
				if (command_queue.size() > 0 &&
				    $urandom_range(0, 99) >= command_queue[0].idle_pct) begin
					cmd_on_bus = command_queue.pop_front();
					start   <= 1'b1;
					action  <= cmd_on_bus.act;
					coord_x <= cmd_on_bus.x;
					coord_y <= cmd_on_bus.y;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: each done strobe is checked against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		poly_answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: result with none expected, inside_res %0d status %0d",
				         $time, inside_res, status);
				mismatch_count++;
			end else begin
				want = pending_answers.pop_front();
				if (inside_res !== want.in_poly) begin
					$display("%0t: inside_res mismatch, expected %0d, actual %0d",
					         $time, want.in_poly, inside_res);
					mismatch_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
					         $time, want.status, status);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: too long with neither a transaction taken nor a result shown
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_MAX) begin
			$display("%0t: timeout, no progress for %0d cycles", $time, quiet_cycles);
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus generation, reset and end of run
	// ---------------------------------------------------------------
	initial begin
		int r, n_vert, n_query, span, off_x, off_y, bigs, sel, k;
		int lo_x, hi_x, lo_y, hi_y, vx, vy, px, py;
		int vert_x[$];
		int vert_y[$];
		logic keep_old;

		gen_count      = 0;
		bigs           = 0;

		// directed: empty store, unused action, append into an empty store
		queue_cmd(ACT_QUERY, 0, 0);
		queue_cmd(ACT_UNUSED, 5, -5);
		queue_cmd(ACT_APPEND, 10, 10);
		queue_cmd(ACT_QUERY, 10, 10);
		// square over the whole coordinate range, horizontal edges included
		queue_cmd(ACT_START, -8388608, -8388608);
		queue_cmd(ACT_APPEND, 8388607, -8388608);
		queue_cmd(ACT_APPEND, 8388607, 8388607);
		queue_cmd(ACT_APPEND, -8388608, 8388607);
		queue_cmd(ACT_QUERY, 0, 0);
		queue_cmd(ACT_QUERY, -8388608, -8388608);
		queue_cmd(ACT_QUERY, 8388607, 0);
		queue_cmd(ACT_QUERY, -8388608, 0);
		queue_cmd(ACT_QUERY, 0, 8388607);
		queue_cmd(ACT_QUERY, 0, -8388608);
		queue_cmd(ACT_UNUSED, -1, -1);
		// small right triangle: outside box, inside, on the slanted edge, box edges
		queue_cmd(ACT_START, 0, 0);
		queue_cmd(ACT_APPEND, 100, 0);
		queue_cmd(ACT_APPEND, 0, 100);
		queue_cmd(ACT_QUERY, 200, 200);
		queue_cmd(ACT_QUERY, 10, 10);
		queue_cmd(ACT_QUERY, 50, 50);
		queue_cmd(ACT_QUERY, -1, 50);
		queue_cmd(ACT_QUERY, 100, 100);
		queue_cmd(ACT_QUERY, 0, 50);

		// random: mostly whole polygons followed by queries, some noise
		while (gen_count < N_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				// noise: any action, any point
				queue_cmd(2'($urandom_range(0, 3)), rand_coord(0), rand_coord(0));
				continue;
			end
			span = pick_span();
			if ((r < 9 && bigs < 2) || (bigs == 0 && gen_count > 350)) begin
				// fill the store and push a few appends past full
				n_vert  = MAX_VERT + $urandom_range(1, 3);
				n_query = 3;
				bigs++;
			end else if (r < 13) begin
				n_vert  = $urandom_range(1, 2);
				n_query = $urandom_range(1, 3);
			end else begin
				n_vert  = $urandom_range(3, 10);
				n_query = $urandom_range(2, 8);
			end
			// offset small shapes away from the origin now and then
			if (span != 0 && $urandom_range(0, 1)) begin
				off_x = int'($urandom_range(0, 1 << 23)) - (1 << 22);
				off_y = int'($urandom_range(0, 1 << 23)) - (1 << 22);
			end else begin
				off_x = 0;
				off_y = 0;
			end
			// occasionally extend the previous polygon instead of starting anew
			keep_old = ($urandom_range(0, 9) == 0);
			vert_x.delete();
			vert_y.delete();
			for (k = 0; k < n_vert; k++) begin
				vx = off_x + rand_coord(span);
				vy = off_y + rand_coord(span);
				vert_x.insert(vert_x.size(), vx);
				vert_y.insert(vert_y.size(), vy);
				if (k == 0) begin
					lo_x = vx;
					hi_x = vx;
					lo_y = vy;
					hi_y = vy;
				end else begin
					if (vx < lo_x) lo_x = vx;
					if (vx > hi_x) hi_x = vx;
					if (vy < lo_y) lo_y = vy;
					if (vy > hi_y) hi_y = vy;
				end
				queue_cmd((k == 0 && !keep_old) ? ACT_START : ACT_APPEND, vx, vy);
			end
			for (k = 0; k < n_query; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 50) begin
					// anywhere in the box
					px = lo_x + int'($urandom_range(0, hi_x - lo_x));
					py = lo_y + int'($urandom_range(0, hi_y - lo_y));
				end else if (sel < 70) begin
					// exactly on a vertex
					sel = $urandom_range(0, vert_x.size() - 1);
					px  = vert_x[sel];
					py  = vert_y[sel];
				end else if (sel < 85) begin
					// on or just past a box edge
					px = $urandom_range(0, 1) ? lo_x - $urandom_range(0, 1)
					                          : hi_x + $urandom_range(0, 1);
					py = lo_y + int'($urandom_range(0, hi_y - lo_y));
					if ($urandom_range(0, 1)) begin
						px = lo_x + int'($urandom_range(0, hi_x - lo_x));
						py = $urandom_range(0, 1) ? lo_y - $urandom_range(0, 1)
						                          : hi_y + $urandom_range(0, 1);
					end
				end else begin
					px = off_x + rand_coord(span);
					py = off_y + rand_coord(span);
				end
				queue_cmd(ACT_QUERY, px, py);
			end
		end

		// single reset at the start of the run
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// all transactions taken, then all results seen, then a short drain
		do @(posedge clk); while (command_queue.size() != 0 || start);
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
rtl/pip_pkg.sv
rtl/point_in_polygon_test_core.sv
rtl/pip_checker.sv
test/tb_top.sv
